>>> hdl/tcsq_pkg.sv
// ============================================================================
// tcsq_pkg
// Shared types and constants of the timed command sequence queue: request and
// result codes, the stored step word and the channel payloads.
// ============================================================================
package tcsq_pkg;

   // Request codes carried in req_type.
   typedef enum logic [1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_TICK    = 2'd1,
      REQ_ABORT   = 2'd2,
      REQ_DRAIN   = 2'd3
   } req_kind_type;

   // Result codes carried in result_kind.
   typedef enum logic [1:0] {
      RES_STATUS  = 2'd0,
      RES_EXECUTE = 2'd1,
      RES_DRAINED = 2'd2,
      RES_DROPPED = 2'd3
   } res_kind_type;

   // Control states of the sequencer.
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_FETCH = 2'd1,
      ST_EMIT  = 2'd2
   } state_type;

   // A drain releases at most this many steps per request.
   localparam int DRAIN_MAX = 16;
   localparam int DRAIN_W   = 5;
   localparam int PEND_W    = 5;

   // One stored step, 64 bits.
   typedef struct packed {
      logic [31:0] payload;
      logic [15:0] delay_ms;
      logic [15:0] command;
   } step_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [15:0]  step_command;
      logic [31:0]  step_payload;
      logic [15:0]  step_delay_ms;
      logic [31:0]  now_ms;
   } req_payload_type;

   typedef struct packed {
      res_kind_type       result_kind;
      logic [15:0]        out_command;
      logic [31:0]        out_payload;
      logic [15:0]        out_delay_ms;
      logic [PEND_W-1:0]  pending_count;
      logic               running;
      logic               last_result;
   } rsp_payload_type;

endpackage

>>> hdl/tcsq_channels.sv
// ============================================================================
// tcsq_channels
// Valid/ready channel interfaces for the request and result beats.
// ============================================================================
interface tcsq_req_if import tcsq_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tcsq_rsp_if import tcsq_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/tcsq_step_mem.sv
// ============================================================================
// tcsq_step_mem
// Step storage: one write port and one read port with registered read data.
// ============================================================================
module tcsq_step_mem import tcsq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  step_type                 wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output step_type                 rd_data
);

   step_type mem [DEPTH];
   step_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/timed_command_sequence_queue.sv
// ============================================================================
// timed_command_sequence_queue
// FIFO of timed command steps released by millisecond ticks or by a drain.
// ============================================================================
// Usage. Requests arrive as beats on req_ch: enqueue a step, tick with the
// current time, abort, or drain. Every request yields one result beat on
// rsp_ch, except a drain of a nonempty queue, which yields one beat per
// released step (at most sixteen) with last_result set on the final one.
// Every result carries the number of steps still queued and the running flag.
// Sequencing: one request is worked on at a time. Enqueue, abort, and ticks
// that release nothing go from idle straight to the emit state, where the
// staged beat moves into the output register. A tick that releases a step
// passes through the fetch state first, and a drain of n steps passes
// through fetch and emit once per released step. The fetch state is set by
// the single read port of the step memory and its registered read data. A
// new request is taken as soon as the previous result sits in the output
// register, even if the receiver has not yet taken that beat.
// Reset (synchronous, active high) empties the queue and disarms the wait;
// the step memory is not cleared and needs no clearing pass. When the
// receiver stalls, the finished beat holds in the output register and the
// sequencer waits before loading the next one.
// ============================================================================
module timed_command_sequence_queue import tcsq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   tcsq_req_if.sink      req_ch,
   tcsq_rsp_if.source    rsp_ch
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // Control state.
   state_type            state_ff, state_in;
   logic [PW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 waiting_ff, waiting_in;
   logic [31:0]          deadline_ff, deadline_in;
   logic                 drain_ff, drain_in;
   logic [DRAIN_W-1:0]   drain_left_ff, drain_left_in;
   logic                 out_valid_ff;

   // Payload registers.
   logic [31:0]          now_ff, now_in;
   rsp_payload_type      res_ff, res_in;
   rsp_payload_type      out_ff;

   // Memory ports.
   logic                 mem_wr;
   logic                 mem_rd;
   step_type             mem_wdata;
   step_type             mem_q;

   // Request decode.
   req_payload_type      req_p;
   logic                 accept;
   logic                 out_free;
   logic                 is_empty;
   logic                 is_full;
   logic                 expired;
   logic                 tick_pop;
   logic                 drain_go;
   logic                 drain_big;
   logic [31:0]          time_diff;
   res_kind_type         kind_sel;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      if (p == PW'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PW'(1);
   endfunction

   function automatic rsp_payload_type make_res(input res_kind_type k,
                                                input step_type s,
                                                input logic with_delay,
                                                input logic [CW-1:0] cnt,
                                                input logic last);
      rsp_payload_type r;
      r.result_kind   = k;
      r.out_command   = s.command;
      r.out_payload   = s.payload;
      r.out_delay_ms  = with_delay ? s.delay_ms : 16'd0;
      r.pending_count = PEND_W'(cnt);
      r.running       = (cnt != '0);
      r.last_result   = last;
      return r;
   endfunction

   assign req_p     = req_ch.payload;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept    = req_ch.valid && (state_ff == ST_IDLE);
   assign out_free  = !out_valid_ff || rsp_ch.ready;

   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff >= CW'(QUEUE_DEPTH));
   // Wrap-safe deadline test: the wait is over once now - deadline is not
   // negative as a signed 32-bit value.
   assign time_diff = req_p.now_ms - deadline_ff;
   assign expired   = !time_diff[31];
   assign tick_pop  = (req_p.req_type == REQ_TICK) && !is_empty &&
                      (!waiting_ff || expired);
   assign drain_go  = (req_p.req_type == REQ_DRAIN) && !is_empty;
   assign drain_big = (32'(count_ff) > 32'(DRAIN_MAX));

   assign mem_wdata.payload  = req_p.step_payload;
   assign mem_wdata.delay_ms = req_p.step_delay_ms;
   assign mem_wdata.command  = req_p.step_command;

   tcsq_step_mem #(
      .DEPTH (QUEUE_DEPTH)
   ) u_step_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wr_ptr_ff),
      .wr_data (mem_wdata),
      .rd_en   (mem_rd),
      .rd_addr (rd_ptr_ff),
      .rd_data (mem_q)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (tick_pop || drain_go) ? ST_FETCH : ST_EMIT;
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               if (drain_ff && (drain_left_ff > DRAIN_W'(1))) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Queue bookkeeping, memory accesses and result staging. The sequencer
   // never writes and reads the memory in the same cycle, and an entry is
   // always read by a later request than the one that wrote it.
   always_comb begin
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      count_in      = count_ff;
      waiting_in    = waiting_ff;
      deadline_in   = deadline_ff;
      drain_in      = drain_ff;
      drain_left_in = drain_left_ff;
      now_in        = now_ff;
      res_in        = res_ff;
      mem_wr        = 1'b0;
      mem_rd        = 1'b0;
      kind_sel      = RES_STATUS;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_p.req_type)
                  REQ_ENQUEUE: begin
                     if (is_full) begin
                        kind_sel = RES_DROPPED;
                     end else begin
                        mem_wr    = 1'b1;
                        wr_ptr_in = next_ptr(wr_ptr_ff);
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  REQ_TICK: begin
                     now_in = req_p.now_ms;
                     if (is_empty) begin
                        waiting_in = 1'b0;
                     end else if (tick_pop) begin
                        // The wait is rearmed once the released step is read.
                        mem_rd     = 1'b1;
                        rd_ptr_in  = next_ptr(rd_ptr_ff);
                        count_in   = count_ff - CW'(1);
                        waiting_in = 1'b0;
                     end
                  end
                  REQ_ABORT: begin
                     rd_ptr_in   = '0;
                     wr_ptr_in   = '0;
                     count_in    = '0;
                     waiting_in  = 1'b0;
                     deadline_in = '0;
                  end
                  REQ_DRAIN: begin
                     waiting_in  = 1'b0;
                     deadline_in = '0;
                     if (is_empty) begin
                        rd_ptr_in = '0;
                        wr_ptr_in = '0;
                     end else begin
                        mem_rd    = 1'b1;
                        rd_ptr_in = next_ptr(rd_ptr_ff);
                        drain_in  = 1'b1;
                        if (drain_big) begin
                           drain_left_in = DRAIN_W'(DRAIN_MAX);
                           count_in      = count_ff - CW'(DRAIN_MAX);
                        end else begin
                           drain_left_in = DRAIN_W'(count_ff);
                           count_in      = '0;
                        end
                     end
                  end
                  default: begin
                     kind_sel = RES_STATUS;
                  end
               endcase
               res_in = make_res(kind_sel, '0, 1'b0, count_in, 1'b1);
            end
         end
         ST_FETCH: begin
            if (drain_ff) begin
               res_in = make_res(RES_DRAINED, mem_q, 1'b1, count_ff,
                                 drain_left_ff == DRAIN_W'(1));
            end else begin
               res_in = make_res(RES_EXECUTE, mem_q, 1'b0, count_ff, 1'b1);
               if ((mem_q.delay_ms != 16'd0) && (count_ff != '0)) begin
                  deadline_in = now_ff + 32'(mem_q.delay_ms);
                  waiting_in  = 1'b1;
               end else begin
                  waiting_in  = 1'b0;
               end
            end
         end
         ST_EMIT: begin
            if (out_free && drain_ff) begin
               if (drain_left_ff > DRAIN_W'(1)) begin
                  drain_left_in = drain_left_ff - DRAIN_W'(1);
                  mem_rd        = 1'b1;
                  rd_ptr_in     = next_ptr(rd_ptr_ff);
               end else begin
                  drain_in = 1'b0;
                  if (count_ff == '0) begin
                     rd_ptr_in = '0;
                     wr_ptr_in = '0;
                  end
               end
            end
         end
         default: begin
            drain_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         count_ff      <= '0;
         waiting_ff    <= 1'b0;
         deadline_ff   <= '0;
         drain_ff      <= 1'b0;
         drain_left_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         count_ff      <= count_in;
         waiting_ff    <= waiting_in;
         deadline_ff   <= deadline_in;
         drain_ff      <= drain_in;
         drain_left_ff <= drain_left_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      res_ff <= res_in;
   end

   // Output register: a staged result moves here once the previous beat has
   // been taken or is being taken in the same cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if ((state_ff == ST_EMIT) && out_free) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_EMIT) && out_free) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_ff;

`ifndef SYNTHESIS
   // The queue never holds more steps than it has entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("step count exceeds queue depth");

   // A deadline is only armed while steps remain queued.
   a_wait_needs_steps: assert property (@(posedge clock) disable iff (reset)
      waiting_ff |-> (count_ff != '0))
      else $error("deadline armed on an empty queue");

   // A drain fetch always has a step left to release.
   a_drain_left: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FETCH) && drain_ff) |-> (drain_left_ff != '0))
      else $error("drain fetch with no steps left");

   // Only drained steps can be followed by further beats of the same request.
   a_last_only_drain: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.last_result) |-> (out_ff.result_kind == RES_DRAINED))
      else $error("non-final beat that is not a drained step");
`endif

endmodule

>>> tb/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for timed_command_sequence_queue. Request beats drive
// enqueues, ticks, aborts and drains; a step-queue predictor inside a small
// scoreboard class works out the result beats that each accepted request must
// produce. Every result beat is then checked field by field, in order.
// ============================================================================
module testbench;
   import tcsq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int RANDOM_ITEMS = 142;
   // The slowest run is about 170 requests, each one a full drain of sixteen
   // beats with the longest ready stall on every beat, so this limit leaves
   // a wide margin.
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_SETTLE = 40;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the step queue and the deadline state.
   // Accepted requests go in through note_request, which queues the expected
   // result beats. Results that the block emits are checked by check_response.
   // -------------------------------------------------------------------------
   class step_scoreboard;
      step_type        queued_steps[$];
      bit              wait_armed;
      logic [31:0]     wake_ms;
      rsp_payload_type pending_results[$];
      int unsigned     errors;
      int unsigned     req_seen[4];
      int unsigned     kind_seen[4];

      function new();
         errors = 0;
         foreach (req_seen[i]) req_seen[i] = 0;
         foreach (kind_seen[i]) kind_seen[i] = 0;
         clear_queue();
      endfunction

      function void clear_queue();
         queued_steps.delete();
         wait_armed = 1'b0;
         wake_ms = '0;
      endfunction

      function int unsigned outstanding();
         return pending_results.size();
      endfunction

      // The pending count and the running flag always reflect the queue as
      // it stands after the whole request has been worked on.
      function void push_result(res_kind_type kind, step_type s, bit with_delay,
                                bit last);
         rsp_payload_type r;
         r.result_kind   = kind;
         r.out_command   = s.command;
         r.out_payload   = s.payload;
         r.out_delay_ms  = with_delay ? s.delay_ms : 16'd0;
         r.pending_count = PEND_W'(queued_steps.size());
         r.running       = (queued_steps.size() != 0);
         r.last_result   = last;
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void note_request(req_payload_type r);
         step_type s;
         step_type drained[$];
         logic [31:0] lag_ms;
         req_seen[r.req_type]++;
         case (r.req_type)
            REQ_ENQUEUE: begin
               if (queued_steps.size() >= QUEUE_DEPTH) begin
                  push_result(RES_DROPPED, '0, 1'b0, 1'b1);
               end else begin
                  s.command  = r.step_command;
                  s.payload  = r.step_payload;
                  s.delay_ms = r.step_delay_ms;
                  queued_steps.insert(queued_steps.size(), s);
                  push_result(RES_STATUS, '0, 1'b0, 1'b1);
               end
            end
            REQ_TICK: begin
               // The wait is over once now minus the deadline, taken as a
               // signed 32-bit value, is no longer negative.
               lag_ms = r.now_ms - wake_ms;
               if (queued_steps.size() == 0) begin
                  wait_armed = 1'b0;
                  push_result(RES_STATUS, '0, 1'b0, 1'b1);
               end else if (wait_armed && lag_ms[31]) begin
                  push_result(RES_STATUS, '0, 1'b0, 1'b1);
               end else begin
                  s = queued_steps[0];
                  queued_steps.delete(0);
                  if (s.delay_ms != 0 && queued_steps.size() != 0) begin
                     wake_ms = r.now_ms + 32'(s.delay_ms);
                     wait_armed = 1'b1;
                  end else begin
                     wait_armed = 1'b0;
                  end
                  push_result(RES_EXECUTE, s, 1'b0, 1'b1);
               end
            end
            REQ_ABORT: begin
               clear_queue();
               push_result(RES_STATUS, '0, 1'b0, 1'b1);
            end
            default: begin
               // Drain: with a sixteen-deep queue everything goes out, so the
               // queue is always empty afterwards.
               if (queued_steps.size() == 0) begin
                  clear_queue();
                  push_result(RES_STATUS, '0, 1'b0, 1'b1);
               end else begin
                  while (queued_steps.size() != 0 && drained.size() < DRAIN_MAX) begin
                     drained.insert(drained.size(), queued_steps[0]);
                     queued_steps.delete(0);
                  end
                  wait_armed = 1'b0;
                  wake_ms = '0;
                  foreach (drained[i])
                     push_result(RES_DRAINED, drained[i], 1'b1,
                                 i == drained.size() - 1);
               end
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: mismatch on %s, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, expected none, actual %p",
                     $time, got);
            errors++;
            return;
         end
         want = pending_results[0];
         pending_results.delete(0);
         kind_seen[got.result_kind]++;
         compare_field("result_kind", want.result_kind, got.result_kind);
         compare_field("out_command", want.out_command, got.out_command);
         compare_field("out_payload", want.out_payload, got.out_payload);
         compare_field("out_delay_ms", want.out_delay_ms, got.out_delay_ms);
         compare_field("pending_count", want.pending_count, got.pending_count);
         compare_field("running", want.running, got.running);
         compare_field("last_result", want.last_result, got.last_result);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block itself.
   // -------------------------------------------------------------------------
   logic clock;
   logic reset;
   bit   idle_on;
   int unsigned cycle_count;
   step_scoreboard board;

   tcsq_req_if req_if ();
   tcsq_rsp_if rsp_if ();

   timed_command_sequence_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL timed_command_sequence_queue");
      $finish;
   end

   // Monitor. Sampling at the edge sees the values that were present when the
   // handshake happened, since every signal changes by nonblocking update.
   // A request noted at the same edge as a result cannot have caused it, as
   // each result passes the staging and output registers before it is taken.
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_if.valid && req_if.ready)
            board.note_request(req_if.payload);
         if (rsp_if.valid && rsp_if.ready)
            board.check_response(rsp_if.payload);
      end
   end

   // Result side: ready drops in random bursts while idling
   // is enabled, and stays high otherwise.
   initial begin
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Drives one request beat and returns at the edge where it is accepted.
   // Valid only drops for an idle burst, so back-to-back beats keep it high.
   task automatic send_request(req_kind_type kind, logic [15:0] command,
                               logic [31:0] payload, logic [15:0] delay_ms,
                               logic [31:0] now_ms);
      req_payload_type p;
      p.req_type      = kind;
      p.step_command  = command;
      p.step_payload  = payload;
      p.step_delay_ms = delay_ms;
      p.now_ms        = now_ms;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus.
   // -------------------------------------------------------------------------
   initial begin
      logic [31:0]  sim_ms;
      int unsigned  pick;
      int unsigned  burst_left;
      logic [15:0]  delay_ms;
      req_kind_type kind;

      board = new();
      idle_on = 1'b1;
      reset <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A tick and a drain on the empty queue come first.
      send_request(REQ_TICK, 16'h0, 32'h0, 16'h0, 32'h0);
      send_request(REQ_DRAIN, 16'h0, 32'h0, 16'h0, 32'h0);

      // Steps with all-ones and all-zero fields, then a short delay.
      send_request(REQ_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(REQ_ENQUEUE, 16'h0000, 32'h0000_0000, 16'h0000, 32'h0);
      send_request(REQ_ENQUEUE, 16'h1234, 32'hA5A5_5A5A, 16'd5, 32'h0);

      // The first release arms a deadline that wraps past 2^32 to 0x0000FFEF.
      // The next two ticks are early (the second one by a single millisecond),
      // the third lands exactly on the deadline and releases the zero-delay
      // step, which leaves the wait disarmed.
      send_request(REQ_TICK, 16'h0, 32'h0, 16'h0, 32'hFFFF_FFF0);
      send_request(REQ_TICK, 16'h0, 32'h0, 16'h0, 32'hFFFF_FFFF);
      send_request(REQ_TICK, 16'h0, 32'h0, 16'h0, 32'h0000_FFEE);
      send_request(REQ_TICK, 16'h0, 32'h0, 16'h0, 32'h0000_FFEF);

      // Abort with one step still queued.
      send_request(REQ_ABORT, 16'h0, 32'h0, 16'h0, 32'h0);

      // Fill the queue, overflow it by one, then drain all sixteen steps.
      repeat (QUEUE_DEPTH)
         send_request(REQ_ENQUEUE, 16'($urandom), $urandom,
                      16'($urandom_range(0, 20)), $urandom);
      send_request(REQ_ENQUEUE, 16'hBEEF, 32'hDEAD_BEEF, 16'd1, 32'h0);
      send_request(REQ_DRAIN, 16'h0, 32'h0, 16'h0, 32'h0);

      // Random part. Time mostly moves forward in small steps so that armed
      // deadlines are met; now and then it jumps far ahead or to an arbitrary
      // value. Enqueue bursts refill the queue up to the full condition.
      sim_ms = $urandom;
      burst_left = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // Idling comes in stretches, with quiet gaps, and stops near the end.
         idle_on = (i < RANDOM_ITEMS - 40) && ((i / 20) % 3 != 2);
         if (burst_left == 0 && $urandom_range(0, 19) == 0)
            burst_left = $urandom_range(8, 18);
         pick = $urandom_range(0, 99);
         if (burst_left != 0) begin
            kind = REQ_ENQUEUE;
            burst_left--;
         end else if (pick < 45) begin
            kind = REQ_ENQUEUE;
         end else if (pick < 86) begin
            kind = REQ_TICK;
         end else if (pick < 93) begin
            kind = REQ_ABORT;
         end else begin
            kind = REQ_DRAIN;
         end

         pick = $urandom_range(0, 9);
         if (pick < 3)
            delay_ms = 16'd0;
         else if (pick < 9)
            delay_ms = 16'($urandom_range(1, 10));
         else
            delay_ms = 16'($urandom);

         if (kind == REQ_TICK) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               sim_ms = $urandom;
            else if (pick < 3)
               sim_ms = sim_ms + $urandom_range(0, 70000);
            else
               sim_ms = sim_ms + $urandom_range(0, 8);
         end

         // Fields that the request type ignores still carry random values.
         send_request(kind, 16'($urandom), $urandom, delay_ms,
                      kind == REQ_TICK ? sim_ms : $urandom);
      end
      req_if.valid <= 1'b0;

      // Wait for every expected beat, then a little longer to catch extras.
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);

      $display("Requests: %0d enqueue, %0d tick, %0d abort, %0d drain.",
               board.req_seen[REQ_ENQUEUE], board.req_seen[REQ_TICK],
               board.req_seen[REQ_ABORT], board.req_seen[REQ_DRAIN]);
      $display("Results checked: %0d status, %0d executed, %0d drained, %0d dropped.",
               board.kind_seen[RES_STATUS], board.kind_seen[RES_EXECUTE],
               board.kind_seen[RES_DRAINED], board.kind_seen[RES_DROPPED]);
      if (board.errors == 0 && board.outstanding() == 0)
         $display("PASS timed_command_sequence_queue");
      else
         $display("FAIL timed_command_sequence_queue");
      $finish;
   end

endmodule
